FILE: rtl/core/eicq_pkg.sv
// ----------------------------------------------------------------------------
// eicq_pkg
// shared widths and reset constants for the eisenstein coefficient reducer
// ----------------------------------------------------------------------------
package eicq_pkg;

	localparam int COEFF_W = 32;             // width of each coefficient part
	localparam int MOD_W   = 14;             // width of the modulus q
	localparam int REM_W   = 15;             // width of a signed result part

	localparam logic [MOD_W-1:0] MOD_RESET = 14'd701;

	// dividend bits consumed by one lane stage
	localparam int EICQ_STEP_BITS = 4;

endpackage

FILE: rtl/core/eicq_lane.sv
// ----------------------------------------------------------------------------
// eicq_lane
// pipelined restoring remainder of one 32-bit part modulo q
// ----------------------------------------------------------------------------
module eicq_lane import eicq_pkg::*; #(
	parameter int STEP_BITS = EICQ_STEP_BITS
) (
	input  logic               clk,
	input  logic [COEFF_W-1:0] coeff,
	input  logic [MOD_W-1:0]   modulus,
	output logic [MOD_W-1:0]   rem
);

	localparam int NSTG = COEFF_W / STEP_BITS;

	// one restoring step: shift in a dividend bit, subtract q when it fits
	function automatic logic [MOD_W-1:0] mod_step(
		input logic [MOD_W-1:0] r,
		input logic             b,
		input logic [MOD_W-1:0] q
	);
		logic [MOD_W:0] t;
		logic [MOD_W:0] d;
		t = {r, b};
		d = t - {1'b0, q};
		if (t >= {1'b0, q}) begin
			return d[MOD_W-1:0];
		end
		return t[MOD_W-1:0];
	endfunction

	logic [MOD_W-1:0]   rem_s [NSTG];
	logic [COEFF_W-1:0] div_s [NSTG-1];

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic [MOD_W-1:0]   r_in;
		logic [COEFF_W-1:0] d_in;
		logic [MOD_W-1:0]   r_nxt;
		logic [COEFF_W-1:0] d_nxt;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign d_in = coeff;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = div_s[k-1];
		end

		always_comb begin
			r_nxt = r_in;
			d_nxt = d_in;
			for (int j = 0; j < STEP_BITS; j++) begin
				r_nxt = mod_step(r_nxt, d_nxt[COEFF_W-1], modulus);
				d_nxt = {d_nxt[COEFF_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= r_nxt;
		end

		if (k < NSTG - 1) begin : g_div
			always_ff @(posedge clk) begin
				div_s[k] <= d_nxt;
			end
		end
	end

	// a zero modulus reduces everything to zero
	assign rem = (modulus == '0) ? '0 : rem_s[NSTG-1];

endmodule

FILE: rtl/core/eicq_region.sv
// ----------------------------------------------------------------------------
// eicq_region
// merges both lane remainders into the hexagonal representative
// ----------------------------------------------------------------------------
module eicq_region import eicq_pkg::*; (
	input  logic                    clk,
	input  logic [MOD_W-1:0]        x,
	input  logic [MOD_W-1:0]        y,
	input  logic [MOD_W-1:0]        modulus,
	output logic signed [REM_W-1:0] rem_real,
	output logic signed [REM_W-1:0] rem_omega
);

	localparam int CALC_W = MOD_W + 3;

	logic signed [CALC_W-1:0] xs, ys, qs, dx, dy, rx, ry;
	logic                     t1, t2, t3;

	assign xs = $signed({3'b000, x});
	assign ys = $signed({3'b000, y});
	assign qs = $signed({3'b000, modulus});
	assign dx = xs <<< 1;
	assign dy = ys <<< 1;

	assign t1 = (xs + ys > qs) && (dx > ys) && (dy >= xs);
	assign t2 = (dx - ys > qs) && (dy < xs);
	assign t3 = (dy - xs >= qs) && (dx <= ys);

	always_comb begin
		if (modulus == MOD_W'(2)) begin
			// (1,1) folds to (-1,-1), anything else passes
			if (x == MOD_W'(1) && y == MOD_W'(1)) begin
				rx = -CALC_W'(1);
				ry = -CALC_W'(1);
			end else begin
				rx = xs;
				ry = ys;
			end
		end else begin
			rx = ((t1 || t2) && !t3) ? xs - qs : xs;
			ry = ((t1 || t3) && !t2) ? ys - qs : ys;
		end
	end

	always_ff @(posedge clk) begin
		rem_real  <= rx[REM_W-1:0];
		rem_omega <= ry[REM_W-1:0];
	end

endmodule

FILE: rtl/core/eisenstein_coeff_mod_q_unit.sv
// ----------------------------------------------------------------------------
// eisenstein_coeff_mod_q_unit
// reduces an eisenstein coefficient a + b*w modulo q into the hexagonal domain
// ----------------------------------------------------------------------------
//  channel   signals                          direction  transfer
//  command   start, busy, coeff_real/omega     in         start && !busy
//  result    done, rem_real, rem_omega         out        done (one cycle)
//  config    modulus_we, modulus_wdata         in         modulus_we
//
//  one coefficient can enter every cycle; busy is always low
//  the remainder lanes resolve STEP_BITS quotient bits per stage, then one merge stage
//  reset clears the valid pipeline and loads q = 701
//  the receiver cannot stall; every result shows for exactly one cycle
//  unchecked, the user ensures the modulus is only written while no coefficient is in flight
// ----------------------------------------------------------------------------
module eisenstein_coeff_mod_q_unit import eicq_pkg::*; #(
	parameter int STEP_BITS = EICQ_STEP_BITS   // must divide COEFF_W, below COEFF_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command side
	input  logic                    start,
	output logic                    busy,
	input  logic [COEFF_W-1:0]      coeff_real,
	input  logic [COEFF_W-1:0]      coeff_omega,
	// result side
	output logic                    done,
	output logic signed [REM_W-1:0] rem_real,
	output logic signed [REM_W-1:0] rem_omega,
	// modulus register
	input  logic                    modulus_we,
	input  logic [MOD_W-1:0]        modulus_wdata
);

	localparam int NSTG = COEFF_W / STEP_BITS;

	logic [MOD_W-1:0] modulus_q;
	logic [NSTG:0]    vld_q;      // one valid bit per stage, lanes then merge
	logic [MOD_W-1:0] x_rem;
	logic [MOD_W-1:0] y_rem;
	logic             accept;

	// fully pipelined, so a new transfer is always welcome
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// modulus register; the user must write it only between bursts, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	// valid bits ride alongside the payload stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NSTG-1:0], accept};
		end
	end

	assign done = vld_q[NSTG];

	// real part lane
	eicq_lane #(
		.STEP_BITS (STEP_BITS)
	) u_lane_real (
		.clk     (clk),
		.coeff   (coeff_real),
		.modulus (modulus_q),
		.rem     (x_rem)
	);

	// omega part lane
	eicq_lane #(
		.STEP_BITS (STEP_BITS)
	) u_lane_omega (
		.clk     (clk),
		.coeff   (coeff_omega),
		.modulus (modulus_q),
		.rem     (y_rem)
	);

	// region tests combine both lanes
	eicq_region u_region (
		.clk       (clk),
		.x         (x_rem),
		.y         (y_rem),
		.modulus   (modulus_q),
		.rem_real  (rem_real),
		.rem_omega (rem_omega)
	);

	// signed copy of q for range checks
	logic signed [REM_W:0] q_sgn;
	assign q_sgn = $signed({2'b00, modulus_q});

	// every result comes from an earlier transfer through the lane and merge stages
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, NSTG + 1))
		else $error("result strobe without matching transfer");

	// lane remainders stay below q
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG-1] && modulus_q != '0) |-> (x_rem < modulus_q && y_rem < modulus_q))
		else $error("lane remainder not below modulus");

	// for q above 2, representatives lie strictly between -q and q
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && modulus_q > MOD_W'(2)) |->
		($signed(rem_real) > -q_sgn && $signed(rem_real) < q_sgn &&
		 $signed(rem_omega) > -q_sgn && $signed(rem_omega) < q_sgn))
		else $error("result outside hexagonal range");

endmodule

FILE: tb/sv/eisenstein_coeff_mod_q_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eisenstein_coeff_mod_q_unit_tb
// self-checking bench for the eisenstein coefficient reducer: a directed
// table, then random phases over several moduli, each checked against a
// table value or an in-bench model of the hexagonal-domain reduction
// ----------------------------------------------------------------------------
module eisenstein_coeff_mod_q_unit_tb;
	import eicq_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int PIPE_DEPTH  = COEFF_W / EICQ_STEP_BITS + 1;  // lane stages plus merge
	localparam int SETTLE      = PIPE_DEPTH + 4;
	localparam int PHASE_ITEMS = 150;
	localparam int N_PHASES    = 12;
	localparam int N_VECTORS   = 25;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic signed [REM_W-1:0] re;
		logic signed [REM_W-1:0] om;
	} rem_pair_t;

	// one row of the directed table; want is only used when known is set
	typedef struct packed {
		logic [MOD_W-1:0]   q;
		logic [COEFF_W-1:0] a;
		logic [COEFF_W-1:0] b;
		logic               known;
		rem_pair_t          want;
	} vector_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [COEFF_W-1:0]      coeff_real;
	logic [COEFF_W-1:0]      coeff_omega;
	logic                    done;
	logic signed [REM_W-1:0] rem_real;
	logic signed [REM_W-1:0] rem_omega;
	logic                    modulus_we;
	logic [MOD_W-1:0]        modulus_wdata;

	rem_pair_t        expected_rems[$];     // results still owed by the block
	rem_pair_t        head;
	logic [MOD_W-1:0] cur_q = MOD_RESET;    // bench copy of the modulus register
	bit               failed = 1'b0;
	int               cycle_count = 0;
	int               burst_left = 0;
	vector_t          directed [N_VECTORS];
	int unsigned      phase_moduli [N_PHASES];

	eisenstein_coeff_mod_q_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.coeff_real    (coeff_real),
		.coeff_omega   (coeff_omega),
		.done          (done),
		.rem_real      (rem_real),
		.rem_omega     (rem_omega),
		.modulus_we    (modulus_we),
		.modulus_wdata (modulus_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction: reduce both parts mod q, then fold into the hexagon
	// ------------------------------------------------------------------------
	function automatic rem_pair_t hex_reduce(input logic [MOD_W-1:0] q,
			input logic [COEFF_W-1:0] a, input logic [COEFF_W-1:0] b);
		int        qs, x, y, rx, ry;
		bit        t1, t2, t3;
		rem_pair_t r;
		qs = int'(q);
		x  = int'(a % COEFF_W'(q));
		y  = int'(b % COEFF_W'(q));
		if (qs == 2) begin
			// only (1,1) leaves the domain for q = 2, and it goes to (-1,-1)
			rx = (x == 1 && y == 1) ? -1 : x;
			ry = (x == 1 && y == 1) ? -1 : y;
		end else begin
			t1 = (x + y > qs) && (2 * x > y) && (2 * y >= x);
			t2 = (2 * x - y > qs) && (2 * y < x);
			t3 = (2 * y - x >= qs) && (2 * x <= y);
			rx = ((t1 || t2) && !t3) ? x - qs : x;
			ry = ((t1 || t3) && !t2) ? y - qs : y;
		end
		r.re = REM_W'(rx);
		r.om = REM_W'(ry);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------------

	// present one coefficient and hold it until the block takes the transfer
	task automatic transfer_coeff(input logic [COEFF_W-1:0] a, input logic [COEFF_W-1:0] b,
			input logic known, input rem_pair_t want);
		@(negedge clk);
		start       <= 1'b1;
		coeff_real  <= a;
		coeff_omega <= b;
		do @(posedge clk); while (busy);
		expected_rems.push_back(known ? want : hex_reduce(cur_q, a, b));
	endtask

	// bursts of random length, each followed by a random gap (often none)
	task automatic pace_sender();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				start       <= 1'b0;
				// junk on the data lines while start is low must be ignored
				coeff_real  <= $urandom;
				coeff_omega <= $urandom;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// drain the pipe completely, then load a new modulus
	task automatic write_modulus(input logic [MOD_W-1:0] q);
		@(negedge clk);
		start <= 1'b0;
		while (expected_rems.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		modulus_we    <= 1'b1;
		modulus_wdata <= q;
		@(negedge clk);
		modulus_we    <= 1'b0;
		modulus_wdata <= MOD_W'($urandom);
		cur_q = q;
	endtask

	function automatic logic [COEFF_W-1:0] extreme_part();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h1 << $urandom_range(0, COEFF_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// random coefficient pair, biased toward small values, the hexagon edges
	// and the extremes of the 32-bit range
	task automatic random_pair(output logic [COEFF_W-1:0] a, output logic [COEFF_W-1:0] b);
		int          qs, x, y;
		int unsigned kmax;
		qs   = int'(cur_q);
		kmax = 32'hFFFF_FFFF / cur_q;
		case ($urandom_range(0, 5))
			0, 1: begin
				a = $urandom;
				b = $urandom;
			end
			2: begin
				a = $urandom_range(0, 3 * qs);
				b = $urandom_range(0, 3 * qs);
			end
			3, 4: begin
				// pick x, then put y on or next to one of the region lines
				x = $urandom_range(0, qs - 1);
				case ($urandom_range(0, 4))
					0: y = qs - x;              // x + y = q
					1: y = 2 * x - qs;          // 2x - y = q
					2: y = (x + qs) / 2;        // 2y - x = q
					3: y = 2 * x;               // 2x = y
					default: y = x / 2;         // 2y = x
				endcase
				y = y + $urandom_range(0, 2) - 1;
				y = ((y % qs) + qs) % qs;
				// lift both back to full-width multiples of q, wrap is harmless
				a = $urandom_range(0, kmax) * cur_q + x;
				b = $urandom_range(0, kmax) * cur_q + y;
			end
			default: begin
				a = extreme_part();
				b = extreme_part();
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// result side: every done pulse is a transfer, no back-pressure exists
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rems.size() == 0) begin
				$display("%0t: result with nothing pending: rem_real=%0d rem_omega=%0d",
				         $time, rem_real, rem_omega);
				failed = 1'b1;
			end else begin
				head = expected_rems.pop_front();
				if (rem_real !== head.re || rem_omega !== head.om) begin
					$display("%0t: mismatch: expected (%0d, %0d) got (%0d, %0d)",
					         $time, head.re, head.om, rem_real, rem_omega);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("eisenstein_coeff_mod_q_unit_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [COEFF_W-1:0] a, b;

		// rows with known set carry results that follow directly from the
		// region rules; the rest go through the predictor
		directed = '{
			// reset modulus 701: corners, midpoints and the region lines
			'{14'd701,   32'd0,          32'd0,          1'b1, '{15'sd0,     15'sd0}},
			'{14'd701,   32'd700,        32'd0,          1'b1, '{-15'sd1,    15'sd0}},
			'{14'd701,   32'd0,          32'd700,        1'b1, '{15'sd0,     -15'sd1}},
			'{14'd701,   32'd700,        32'd700,        1'b1, '{-15'sd1,    -15'sd1}},
			'{14'd701,   32'd350,        32'd350,        1'b1, '{15'sd350,   15'sd350}},
			'{14'd701,   32'd351,        32'd351,        1'b1, '{-15'sd350,  -15'sd350}},
			'{14'd701,   32'd701,        32'd1402,       1'b1, '{15'sd0,     15'sd0}},
			'{14'd701,   32'd1,          32'd351,        1'b0, '{15'sd0,     15'sd0}},
			'{14'd701,   32'd351,        32'd1,          1'b0, '{15'sd0,     15'sd0}},
			'{14'd701,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, '{15'sd0,     15'sd0}},
			'{14'd701,   32'd0,          32'hFFFF_FFFF,  1'b0, '{15'sd0,     15'sd0}},
			'{14'd701,   32'h8000_0000,  32'h7FFF_FFFF,  1'b0, '{15'sd0,     15'sd0}},
			'{14'd701,   32'd468,        32'd234,        1'b0, '{15'sd0,     15'sd0}},
			// modulus two: only (1,1) is folded
			'{14'd2,     32'd1,          32'd1,          1'b1, '{-15'sd1,    -15'sd1}},
			'{14'd2,     32'd0,          32'd0,          1'b1, '{15'sd0,     15'sd0}},
			'{14'd2,     32'd1,          32'd0,          1'b1, '{15'sd1,     15'sd0}},
			'{14'd2,     32'd0,          32'd1,          1'b1, '{15'sd0,     15'sd1}},
			'{14'd2,     32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{-15'sd1,    -15'sd1}},
			'{14'd2,     32'd2,          32'd3,          1'b1, '{15'sd0,     15'sd1}},
			// largest modulus
			'{14'd16383, 32'd16382,      32'd16382,      1'b1, '{-15'sd1,    -15'sd1}},
			'{14'd16383, 32'd16382,      32'd0,          1'b1, '{-15'sd1,    15'sd0}},
			'{14'd16383, 32'd0,          32'd16382,      1'b1, '{15'sd0,     -15'sd1}},
			'{14'd16383, 32'd8191,       32'd8191,       1'b1, '{15'sd8191,  15'sd8191}},
			'{14'd16383, 32'd8192,       32'd8192,       1'b1, '{-15'sd8191, -15'sd8191}},
			'{14'd16383, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, '{15'sd0,     15'sd0}}
		};

		// moduli for the random phases: both range ends, the reset value,
		// neighbors of the ends, 8191, then four drawn at random
		phase_moduli[0]  = 2;
		phase_moduli[1]  = 16383;
		phase_moduli[2]  = 3;
		phase_moduli[3]  = 701;
		phase_moduli[4]  = 4;
		phase_moduli[5]  = 16382;
		phase_moduli[6]  = 8191;
		phase_moduli[7]  = 5;
		phase_moduli[8]  = $urandom_range(6, 64);
		phase_moduli[9]  = $urandom_range(2, 16383);
		phase_moduli[10] = $urandom_range(2, 16383);
		phase_moduli[11] = $urandom_range(2, 16383);

		// every input known from time zero while reset is held
		arst_n        = 1'b0;
		start         = 1'b0;
		coeff_real    = '0;
		coeff_omega   = '0;
		modulus_we    = 1'b0;
		modulus_wdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, modulus switched whenever a row asks for another
		foreach (directed[i]) begin
			if (directed[i].q != cur_q)
				write_modulus(directed[i].q);
			transfer_coeff(directed[i].a, directed[i].b, directed[i].known, directed[i].want);
			pace_sender();
		end

		// random phases, one modulus each
		foreach (phase_moduli[p]) begin
			write_modulus(MOD_W'(phase_moduli[p]));
			repeat (PHASE_ITEMS) begin
				random_pair(a, b);
				transfer_coeff(a, b, 1'b0, '0);
				pace_sender();
			end
		end

		// wait out the pipe, then leave room for any stray result
		@(negedge clk);
		start <= 1'b0;
		while (expected_rems.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (!failed)
			$display("eisenstein_coeff_mod_q_unit_tb OK");
		else
			$display("eisenstein_coeff_mod_q_unit_tb NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/eicq_pkg.sv
rtl/core/eicq_lane.sv
rtl/core/eicq_region.sv
rtl/core/eisenstein_coeff_mod_q_unit.sv
tb/sv/eisenstein_coeff_mod_q_unit_tb.sv
